/* hdl/baec_pkg.sv */
// Package for the block-aware escape codec: request and result payload types,
// configuration record, byte codes and register indexes. No dependencies.
`default_nettype none

package baec_pkg;

    // Byte codes of the escape scheme.
    localparam logic [7:0] ESC_BYTE      = 8'h1B;
    localparam logic [7:0] END_BYTE      = 8'hFF;
    localparam logic [7:0] ESC_CODE_END  = 8'h0F;
    localparam logic [7:0] ESC_CODE_ESC  = 8'h0B;
    localparam logic [7:0] LOW_NIBBLE    = 8'h0F;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DIRECTION  = 2'd0;
    localparam logic [1:0] CFG_FIRST_OFFS = 2'd1;
    localparam logic [1:0] CFG_DATA_OFFS  = 2'd2;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam int unsigned CFG_WIDTH     = 12;
    localparam int unsigned CFG_IDX_WIDTH = 2;

    localparam logic [CFG_WIDTH-1:0] FIRST_OFFS_RST = 12'd24;
    localparam logic [CFG_WIDTH-1:0] DATA_OFFS_RST  = 12'd8;

    // Most results one request can give rise to.
    localparam int unsigned MAX_RES = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_start;
        logic       request_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        block_end;
        logic [31:0] logical_pos;
        logic        is_eof;
        logic        request_done;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic                 direction;
        logic [CFG_WIDTH-1:0] first_data_offset;
        logic [CFG_WIDTH-1:0] data_offset;
    } t_cfg;

endpackage

`default_nettype wire

/* hdl/block_aware_escape_codec.sv */
// Top level of the block-aware escape codec: configuration registers, request
// register, stream state, and instances of baec_step and baec_out_buf (baec_pkg).
//
//  Channel   Direction  Handshake                       Payload
//  request   in         i_in_valid / o_in_ready         i_in_data  (t_in_item)
//  result    out        o_out_valid / i_out_ready       o_out_data (t_out_item)
//  config    in         i_cfg_we (no wait, no readback) i_cfg_index, i_cfg_data
//
//  A request is held in an input register, then worked out combinationally into
//  one to three results that wait in the result buffer.
//  Decoding and plain bytes sustain one request per cycle while results are
//  taken; an escaped byte holds the request side until its two results, or
//  three at a block's last slot, are out: the port gives one result per cycle.
//  Reset is synchronous and active low; it loads the register reset values.
//  A stall on the result side fills the buffer and then the input register.
`default_nettype none

module block_aware_escape_codec #(
    parameter int unsigned BLOCK_BYTES = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  baec_pkg::t_in_item                    i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output baec_pkg::t_out_item                   o_out_data,
    input  logic                                  i_cfg_we,
    input  logic [baec_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_index,
    input  logic [baec_pkg::CFG_WIDTH-1:0]        i_cfg_data
);
    import baec_pkg::*;

    localparam int unsigned PW  = $clog2(BLOCK_BYTES);
    localparam int unsigned TOP = BLOCK_BYTES - 2;
    // Position after reset: the first-block offset, clamped like any offset.
    localparam int unsigned RST_POS_I =
        (int'(FIRST_OFFS_RST) > TOP) ? TOP : int'(FIRST_OFFS_RST);
    localparam logic [PW-1:0] RST_POS = PW'(RST_POS_I);

    t_cfg     r_cfg;
    logic     r_in_valid;
    t_in_item r_in;

    // Stream state: slot within the block, pending escape, end seen, count.
    logic [PW-1:0] r_pos;
    logic          r_esc;
    logic          r_eof;
    logic [31:0]   r_count;

    logic [PW-1:0]           n_pos;
    logic                    n_esc, n_eof;
    logic [31:0]             n_count;
    t_out_item [MAX_RES-1:0] w_res;
    logic [1:0]              w_num;
    logic                    w_can_load, w_take;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.direction         <= DIR_ENCODE;
            r_cfg.first_data_offset <= FIRST_OFFS_RST;
            r_cfg.data_offset       <= DATA_OFFS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DIRECTION:  r_cfg.direction         <= i_cfg_data[0];
                CFG_FIRST_OFFS: r_cfg.first_data_offset <= i_cfg_data;
                CFG_DATA_OFFS:  r_cfg.data_offset       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The held request moves on as soon as the result buffer can take its
    // results, so the input register frees in the same cycle.
    assign w_take     = r_in_valid && w_can_load;
    assign o_in_ready = !r_in_valid || w_can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Stream state advances once per request, when its results are stored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= RST_POS;
            r_esc   <= 1'b0;
            r_eof   <= 1'b0;
            r_count <= 32'd0;
        end else if (w_take) begin
            r_pos   <= n_pos;
            r_esc   <= n_esc;
            r_eof   <= n_eof;
            r_count <= n_count;
        end
    end

    baec_step #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_step (
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .i_pos   (r_pos),
        .i_esc   (r_esc),
        .i_eof   (r_eof),
        .i_count (r_count),
        .o_res   (w_res),
        .o_num   (w_num),
        .o_pos   (n_pos),
        .o_esc   (n_esc),
        .o_eof   (n_eof),
        .o_count (n_count)
    );

    baec_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_take),
        .i_res       (w_res),
        .i_num       (w_num),
        .o_can_load  (w_can_load),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready)
    );

    a_pos_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PW'(BLOCK_BYTES - 1))
        else $error("block position beyond the last slot");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_take |=> $stable(r_count) && $stable(r_pos))
        else $error("stream state changed without a request");

    a_eof_decode_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.is_eof) |-> !o_out_data.byte_valid
                                              && !o_out_data.block_end)
        else $error("end-of-stream result carries a byte");

endmodule

`default_nettype wire

/* hdl/baec_step.sv */
// Per-request datapath of the block-aware escape codec: works out all results
// of one request and the next stream state in one pass. Uses baec_pkg.
`default_nettype none

module baec_step #(
    parameter int unsigned BLOCK_BYTES = 4096
) (
    input  baec_pkg::t_in_item                              i_item,
    input  baec_pkg::t_cfg                                  i_cfg,
    input  logic [$clog2(BLOCK_BYTES)-1:0]                  i_pos,
    input  logic                                            i_esc,
    input  logic                                            i_eof,
    input  logic [31:0]                                     i_count,
    output baec_pkg::t_out_item [baec_pkg::MAX_RES-1:0]     o_res,
    output logic [1:0]                                      o_num,
    output logic [$clog2(BLOCK_BYTES)-1:0]                  o_pos,
    output logic                                            o_esc,
    output logic                                            o_eof,
    output logic [31:0]                                     o_count
);
    import baec_pkg::*;

    localparam int unsigned PW  = $clog2(BLOCK_BYTES);
    localparam int unsigned EW  = ((PW > CFG_WIDTH) ? PW : CFG_WIDTH) + 1;
    localparam int unsigned TOP = BLOCK_BYTES - 2;
    localparam logic [PW-1:0] LAST_SLOT = PW'(BLOCK_BYTES - 1);

    // Offsets past the second-last slot clamp to it and keep at least two data slots.
    function automatic logic [PW-1:0] clamp_offs(input logic [CFG_WIDTH-1:0] off);
        logic [EW-1:0] ext;
        ext = EW'(off);
        return (ext > EW'(TOP)) ? PW'(TOP) : PW'(off);
    endfunction

    function automatic t_out_item mk_res(input logic [7:0] b, input logic v,
                                         input logic be, input logic [31:0] c,
                                         input logic eof);
        t_out_item r;
        r.out_byte     = b;
        r.byte_valid   = v;
        r.block_end    = be;
        r.logical_pos  = c;
        r.is_eof       = eof;
        r.request_done = 1'b0;
        r.last         = 1'b0;
        return r;
    endfunction

    logic [PW-1:0] s_pos, clampd, pos1, pos2, adv0, adv1, adv2;
    logic          s_esc, s_eof, last0, last1, last2;
    logic [31:0]   s_cnt, cnt_inc;
    logic [7:0]    b, code, dbyte;
    logic          is_esc, dv, neof, nesc;
    t_out_item [MAX_RES-1:0] res;
    logic [1:0]    num;

    always_comb begin
        b       = i_item.in_byte;
        s_pos   = i_item.stream_start ? clamp_offs(i_cfg.first_data_offset) : i_pos;
        s_esc   = i_item.stream_start ? 1'b0 : i_esc;
        s_eof   = i_item.stream_start ? 1'b0 : i_eof;
        s_cnt   = i_item.stream_start ? 32'd0 : i_count;
        cnt_inc = s_cnt + 32'd1;
        clampd  = clamp_offs(i_cfg.data_offset);

        // Slot chain for up to three physical bytes.
        last0 = (s_pos >= LAST_SLOT);
        adv0  = last0 ? clampd : s_pos + PW'(1);
        pos1  = adv0;
        last1 = (pos1 >= LAST_SLOT);
        adv1  = last1 ? clampd : pos1 + PW'(1);
        pos2  = adv1;
        last2 = (pos2 >= LAST_SLOT);
        adv2  = last2 ? clampd : pos2 + PW'(1);

        is_esc = (b == END_BYTE) || (b == ESC_BYTE);
        code   = b & LOW_NIBBLE;

        res     = '0;
        num     = 2'd1;
        o_pos   = s_pos;
        o_esc   = s_esc;
        o_eof   = s_eof;
        o_count = s_cnt;
        dv      = 1'b0;
        dbyte   = 8'd0;
        neof    = s_eof;
        nesc    = s_esc;

        if (i_cfg.direction == DIR_ENCODE) begin
            if (!is_esc) begin
                res[0]  = mk_res(b, 1'b1, last0, cnt_inc, 1'b0);
                o_pos   = adv0;
                o_count = cnt_inc;
            end else if (!last0) begin
                res[0]  = mk_res(ESC_BYTE, 1'b1, 1'b0, s_cnt, 1'b0);
                res[1]  = mk_res(code, 1'b1, last1, cnt_inc, 1'b0);
                num     = 2'd2;
                o_pos   = adv1;
                o_count = cnt_inc;
            end else begin
                // A bare escape fills the last slot; the byte goes again.
                res[0]  = mk_res(ESC_BYTE, 1'b1, 1'b1, s_cnt, 1'b0);
                res[1]  = mk_res(ESC_BYTE, 1'b1, last1, s_cnt, 1'b0);
                res[2]  = mk_res(code, 1'b1, last2, cnt_inc, 1'b0);
                num     = 2'd3;
                o_pos   = adv2;
                o_count = cnt_inc;
            end
        end else begin
            if (!s_eof) begin
                if (s_esc) begin
                    if (b == END_BYTE) begin
                        neof = 1'b1;
                    end else begin
                        if (b == ESC_CODE_END) begin
                            dbyte = END_BYTE;
                        end else if (b == ESC_CODE_ESC) begin
                            dbyte = ESC_BYTE;
                        end else begin
                            dbyte = b;
                        end
                        nesc = 1'b0;
                        dv   = 1'b1;
                    end
                end else if (b == ESC_BYTE) begin
                    nesc = 1'b1;
                end else if (b == END_BYTE) begin
                    neof = 1'b1;
                end else begin
                    dbyte = b;
                    dv    = 1'b1;
                end
                if (!neof) begin
                    o_count = dv ? cnt_inc : s_cnt;
                    o_pos   = adv0;
                    // An escape left in a block's last slot is dropped.
                    if (last0) begin
                        nesc = 1'b0;
                    end
                end
                o_esc = nesc;
                o_eof = neof;
            end
            res[0] = mk_res(dbyte, dv, 1'b0, o_count, o_eof);
        end

        res[num - 2'd1].request_done = i_item.request_last;
        res[num - 2'd1].last         = 1'b1;
        o_res = res;
        o_num = num;
    end

endmodule

`default_nettype wire

/* hdl/baec_out_buf.sv */
// Result buffer of the block-aware escape codec: holds up to three results of
// one request and hands them out one per accepted beat. Uses baec_pkg.
`default_nettype none

module baec_out_buf (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_load,
    input  baec_pkg::t_out_item [baec_pkg::MAX_RES-1:0] i_res,
    input  logic [1:0]                                  i_num,
    output logic                                        o_can_load,
    output logic                                        o_out_valid,
    output baec_pkg::t_out_item                         o_out_data,
    input  logic                                        i_out_ready
);
    import baec_pkg::*;

    logic                    r_valid;
    logic [1:0]              r_idx, n_idx;
    logic [1:0]              r_num;
    t_out_item [MAX_RES-1:0] r_res;
    logic                    w_final, w_pop, n_valid;

    assign w_final    = (r_idx == r_num - 2'd1);
    assign w_pop      = r_valid && i_out_ready;
    assign o_can_load = !r_valid || (w_pop && w_final);

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (i_load) begin
            n_valid = 1'b1;
            n_idx   = 2'd0;
        end else if (w_pop) begin
            if (w_final) begin
                n_valid = 1'b0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
            r_num   <= 2'd1;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
            if (i_load) begin
                r_num <= i_num;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_res[r_idx];

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_can_load)
        else $error("result buffer overwritten while results were pending");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_num != 2'd0) && (r_idx < r_num))
        else $error("result index beyond the stored results");

    a_step_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_final) |=> r_valid && (r_idx == $past(r_idx) + 2'd1))
        else $error("result skipped or repeated");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_final && !i_load) |=> !r_valid)
        else $error("result buffer still full after final result");

endmodule

`default_nettype wire
